>>> rtl/gaussian_row_blur_rgb_macros.svh
// Assertion macros used by the checker of the horizontal blur block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GAUSSIAN_ROW_BLUR_RGB_MACROS_SVH
`define GAUSSIAN_ROW_BLUR_RGB_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/gbr_pkg.sv
// Shared types and constants for the horizontal Gaussian row blur.
// No dependencies; used by every other file of the block but the macro header.
`default_nettype none

package gbr_pkg;

    // Pixel channel and tap weight widths.
    localparam int PIX_W    = 8;
    localparam int TAP_W    = 16;
    localparam int NUM_TAPS = 8;
    localparam int TAP_IDX_W = $clog2(NUM_TAPS);

    // Default and largest filter radius.
    localparam int RADIUS_DEF = 7;

    // Product of a summed pixel pair and a tap, and the full accumulator.
    localparam int PROD_W = PIX_W + 1 + TAP_W;
    localparam int ACC_W  = 28;

    // Fraction bits dropped from the Q12.16 sum.
    localparam int FRAC_W = 16;

    // Tap weights after reset, center first.
    localparam logic [TAP_W-1:0] TAP_RESET [NUM_TAPS] = '{
        16'd13074, 16'd11538, 16'd7930, 16'd4245,
        16'd1769,  16'd574,   16'd145,  16'd29
    };

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } pix_t;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
    } prod_t;

endpackage

`default_nettype wire

>>> rtl/gbr_if.sv
// Valid/ready channel interfaces for incoming and filtered pixels.
// Depends on gbr_pkg for the channel width.
`default_nettype none

interface gbr_in_if;
    logic                     valid;
    logic                     ready;
    logic [gbr_pkg::PIX_W-1:0] red_in;
    logic [gbr_pkg::PIX_W-1:0] green_in;
    logic [gbr_pkg::PIX_W-1:0] blue_in;
    logic                     row_end;

    modport source (output valid, red_in, green_in, blue_in, row_end, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, row_end, output ready);
endinterface

interface gbr_out_if;
    logic                     valid;
    logic                     ready;
    logic [gbr_pkg::PIX_W-1:0] red_out;
    logic [gbr_pkg::PIX_W-1:0] green_out;
    logic [gbr_pkg::PIX_W-1:0] blue_out;
    logic                     row_last;

    modport source (output valid, red_out, green_out, blue_out, row_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, row_last, output ready);
endinterface

`default_nettype wire

>>> rtl/gaussian_row_blur_rgb.sv
// Horizontal Gaussian row blur, top level: window cells, tap cells, adder stages.
// Depends on gbr_pkg, gbr_if, gbr_cell and gbr_tap.
//
// Use: pixels enter on the "pixel" channel in raster order, one request per
// pixel, with row_end set on the last pixel of each row. Filtered pixels leave
// on the "blurred" channel; row_last marks the final pixel of each row. Tap
// weights (center first) are written through wr_en/wr_index/wr_data while the
// block is idle.
// Throughput: one pixel per clock inside a row, unless blurred.ready stalls the
// pipe. A request with row_end starts a flush of RADIUS extra window shifts with
// the last pixel, during which pixel.ready is low.
// After the window step that completes it, a filtered pixel passes through the
// registered product cells, pair adders, and final adder with saturation; the
// output of pixel x therefore follows the input of pixel x + RADIUS.
// Reset: taps return to their defaults, all pipeline stages empty, and the
// next pixel starts a new row.
// Stall: the output is a register; when blurred.ready is low, each stage keeps
// taking data until it holds a result, so input is taken until the pipe fills.
`default_nettype none

module gaussian_row_blur_rgb
#(
    parameter int RADIUS = gbr_pkg::RADIUS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    gbr_in_if.sink                             pixel,
    gbr_out_if.source                          blurred,
    input  wire logic                          wr_en,
    input  wire logic [gbr_pkg::TAP_IDX_W-1:0] wr_index,
    input  wire logic [gbr_pkg::TAP_W-1:0]     wr_data
);

    localparam int WIN_LEN = 2 * RADIUS + 1;
    localparam int NPROD   = RADIUS + 1;
    localparam int NPART   = (RADIUS + 2) / 2;
    localparam int FILL_W  = $clog2(RADIUS + 2);
    localparam int JW      = $clog2(RADIUS + 1);
    localparam int CW      = FILL_W + 1;

    // Tap weight registers.
    logic [gbr_pkg::TAP_W-1:0] tap_reg [gbr_pkg::NUM_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gbr_pkg::NUM_TAPS; i++)
            begin
                tap_reg[i] <= gbr_pkg::TAP_RESET[i];
            end
        end
        else if (wr_en)
        begin
            tap_reg[wr_index] <= wr_data;
        end
    end

    // Stage enables: a stage moves when it is empty or the next one moves.
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic en0, en1, en2, en3;

    assign en3 = !v3_reg || blurred.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    // Window control: row fill count and the row-end flush sequencer.
    logic              flush_reg, flush_next;
    logic [JW-1:0]     cnt_reg, cnt_next;
    logic [FILL_W-1:0] owed_reg, owed_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] fill_inc;
    logic              v0_next;
    logic              last0_reg, last0_next;
    logic              accept;
    logic              step;
    logic              flush_emit;
    gbr_pkg::pix_t     px_new;
    gbr_pkg::pix_t     px_shift;
    gbr_pkg::pix_t     win [WIN_LEN];

    assign pixel.ready = en0 && !flush_reg;
    assign accept      = pixel.valid && pixel.ready;
    assign step        = accept || (flush_reg && en0);

    assign px_new.r = pixel.red_in;
    assign px_new.g = pixel.green_in;
    assign px_new.b = pixel.blue_in;
    // During a flush the newest pixel is shifted in again (right edge clamp).
    assign px_shift = flush_reg ? win[WIN_LEN-1] : px_new;

    assign fill_inc = (fill_reg == FILL_W'(RADIUS + 1)) ? fill_reg : fill_reg + 1'b1;
    assign flush_emit = (CW'(cnt_reg) + CW'(owed_reg)) >= CW'(RADIUS + 1);

    always_comb
    begin
        flush_next = flush_reg;
        cnt_next   = cnt_reg;
        owed_next  = owed_reg;
        fill_next  = fill_reg;
        v0_next    = v0_reg;
        last0_next = last0_reg;
        if (en0)
        begin
            v0_next = 1'b0;
        end
        if (accept)
        begin
            // A window is emitted once the row holds RADIUS + 1 pixels, also on row end.
            v0_next    = (fill_inc == FILL_W'(RADIUS + 1));
            last0_next = 1'b0;
            if (pixel.row_end)
            begin
                fill_next  = '0;
                flush_next = 1'b1;
                cnt_next   = JW'(1);
                owed_next  = fill_inc;
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
        else if (flush_reg && en0)
        begin
            v0_next    = flush_emit;
            last0_next = (cnt_reg == JW'(RADIUS));
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == JW'(RADIUS))
            begin
                flush_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg <= 1'b0;
            cnt_reg   <= '0;
            owed_reg  <= '0;
            fill_reg  <= '0;
            v0_reg    <= 1'b0;
            last0_reg <= 1'b0;
        end
        else
        begin
            flush_reg <= flush_next;
            cnt_reg   <= cnt_next;
            owed_reg  <= owed_next;
            fill_reg  <= fill_next;
            v0_reg    <= v0_next;
            last0_reg <= last0_next;
        end
    end

    // Window: a chain of pixel cells, newest at the highest index.
    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_win
        gbr_cell u_cell
        (
            .clk      (clk),
            .step     (step),
            .load_all (accept && (fill_reg == '0)),
            .px       (px_new),
            .nbr      ((i == WIN_LEN - 1) ? px_shift : win[(i + 1) % WIN_LEN]),
            .q        (win[i])
        );
    end

    // Tap cells: one per distance from the center.
    gbr_pkg::prod_t prod [NPROD];

    for (genvar k = 0; k < NPROD; k++)
    begin : g_tap
        gbr_tap
        #(
            .CENTER (k == 0)
        )
        u_tap
        (
            .clk  (clk),
            .en   (en1),
            .near (win[RADIUS - k]),
            .far  (win[RADIUS + k]),
            .tap  (tap_reg[k]),
            .prod (prod[k])
        );
    end

    // Valid and row-last marks that travel with the products.
    logic v1_next, v2_next, v3_next;
    logic last1_reg, last2_reg, last3_reg;

    assign v1_next = en1 ? v0_reg : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Pair adders: products summed two at a time.
    logic [gbr_pkg::ACC_W-1:0] part_r_reg [NPART];
    logic [gbr_pkg::ACC_W-1:0] part_g_reg [NPART];
    logic [gbr_pkg::ACC_W-1:0] part_b_reg [NPART];
    logic [gbr_pkg::ACC_W-1:0] part_r_next [NPART];
    logic [gbr_pkg::ACC_W-1:0] part_g_next [NPART];
    logic [gbr_pkg::ACC_W-1:0] part_b_next [NPART];

    always_comb
    begin
        for (int m = 0; m < NPART; m++)
        begin
            part_r_next[m] = gbr_pkg::ACC_W'(prod[2*m].r);
            part_g_next[m] = gbr_pkg::ACC_W'(prod[2*m].g);
            part_b_next[m] = gbr_pkg::ACC_W'(prod[2*m].b);
            if (2 * m + 1 < NPROD)
            begin
                part_r_next[m] = part_r_next[m] + gbr_pkg::ACC_W'(prod[(2*m+1) % NPROD].r);
                part_g_next[m] = part_g_next[m] + gbr_pkg::ACC_W'(prod[(2*m+1) % NPROD].g);
                part_b_next[m] = part_b_next[m] + gbr_pkg::ACC_W'(prod[(2*m+1) % NPROD].b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            part_r_reg <= part_r_next;
            part_g_reg <= part_g_next;
            part_b_reg <= part_b_next;
            last2_reg  <= last1_reg;
        end
        if (en1)
        begin
            last1_reg <= last0_reg;
        end
    end

    // Final sum, drop of the fraction bits and saturation at full scale.
    logic [gbr_pkg::ACC_W-1:0] sum_r, sum_g, sum_b;
    logic [gbr_pkg::PIX_W-1:0] red_reg, green_reg, blue_reg;
    logic [gbr_pkg::PIX_W-1:0] red_next, green_next, blue_next;

    function automatic logic [gbr_pkg::PIX_W-1:0] sat_pix(logic [gbr_pkg::ACC_W-1:0] acc);
        logic [gbr_pkg::ACC_W-gbr_pkg::FRAC_W-1:0] whole;
        whole = acc[gbr_pkg::ACC_W-1:gbr_pkg::FRAC_W];
        if (whole > (gbr_pkg::ACC_W - gbr_pkg::FRAC_W)'({gbr_pkg::PIX_W{1'b1}}))
        begin
            return {gbr_pkg::PIX_W{1'b1}};
        end
        return whole[gbr_pkg::PIX_W-1:0];
    endfunction

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int m = 0; m < NPART; m++)
        begin
            sum_r = sum_r + part_r_reg[m];
            sum_g = sum_g + part_g_reg[m];
            sum_b = sum_b + part_b_reg[m];
        end
        red_next   = sat_pix(sum_r);
        green_next = sat_pix(sum_g);
        blue_next  = sat_pix(sum_b);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last3_reg <= last2_reg;
        end
    end

    assign blurred.valid     = v3_reg;
    assign blurred.red_out   = red_reg;
    assign blurred.green_out = green_reg;
    assign blurred.blue_out  = blue_reg;
    assign blurred.row_last  = last3_reg;

endmodule

`default_nettype wire

>>> rtl/gbr_cell.sv
// One pixel cell of the sliding window: holds an RGB pixel and takes its
// right neighbor's pixel on a shift, or the new pixel on a row start. Uses gbr_pkg.
`default_nettype none

module gbr_cell
(
    input  wire logic          clk,
    input  wire logic          step,
    input  wire logic          load_all,
    input  wire gbr_pkg::pix_t px,
    input  wire gbr_pkg::pix_t nbr,
    output gbr_pkg::pix_t      q
);

    gbr_pkg::pix_t q_reg;
    gbr_pkg::pix_t q_next;

    // A row start fills every cell with the first pixel (left edge replication).
    always_comb
    begin
        q_next = q_reg;
        if (step)
        begin
            q_next = load_all ? px : nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

>>> rtl/gbr_tap.sv
// One tap cell: adds the two window pixels at equal distance from the center
// and multiplies the pair by the tap weight, per channel. Uses gbr_pkg.
`default_nettype none

module gbr_tap
#(
    parameter bit CENTER = 1'b0
)
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire gbr_pkg::pix_t             near,
    input  wire gbr_pkg::pix_t             far,
    input  wire logic [gbr_pkg::TAP_W-1:0] tap,
    output gbr_pkg::prod_t                 prod
);

    localparam int PAIR_W = gbr_pkg::PIX_W + 1;

    logic [PAIR_W-1:0] pair_r;
    logic [PAIR_W-1:0] pair_g;
    logic [PAIR_W-1:0] pair_b;
    gbr_pkg::prod_t    prod_reg;
    gbr_pkg::prod_t    prod_next;

    // The center cell weighs a single pixel; the others weigh a mirrored pair.
    always_comb
    begin
        if (CENTER)
        begin
            pair_r = PAIR_W'(near.r);
            pair_g = PAIR_W'(near.g);
            pair_b = PAIR_W'(near.b);
        end
        else
        begin
            pair_r = PAIR_W'(near.r) + PAIR_W'(far.r);
            pair_g = PAIR_W'(near.g) + PAIR_W'(far.g);
            pair_b = PAIR_W'(near.b) + PAIR_W'(far.b);
        end
        prod_next.r = gbr_pkg::PROD_W'(pair_r) * gbr_pkg::PROD_W'(tap);
        prod_next.g = gbr_pkg::PROD_W'(pair_g) * gbr_pkg::PROD_W'(tap);
        prod_next.b = gbr_pkg::PROD_W'(pair_b) * gbr_pkg::PROD_W'(tap);
    end

    // Product register, held while the stage after it is stalled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/gbr_checker.sv
// Port-level checker for the horizontal blur block, bound to the top level.
// Depends on gaussian_row_blur_rgb_macros.svh and gbr_pkg.
`default_nettype none

`include "gaussian_row_blur_rgb_macros.svh"

module gbr_checker
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      in_row_end,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [gbr_pkg::PIX_W-1:0] out_red,
    input wire logic [gbr_pkg::PIX_W-1:0] out_green,
    input wire logic [gbr_pkg::PIX_W-1:0] out_blue,
    input wire logic                      out_last
);

    // A stalled result keeps its payload until it is taken.
    `GBR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_last))

    // A row-end request always starts a flush that holds off the next pixel.
    `GBR_ASSERT_NEXT(a_flush_starts, clk, rst_n, in_valid && in_ready && in_row_end, !in_ready)

    // With an empty output the block only refuses pixels during a flush.
    `GBR_ASSERT_NOW(a_ready_cause, clk, rst_n, !out_valid, in_ready || $past(in_valid && in_ready && in_row_end) || !$past(in_ready))

endmodule

bind gaussian_row_blur_rgb gbr_checker u_gbr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_row_end (pixel.row_end),
    .out_valid  (blurred.valid),
    .out_ready  (blurred.ready),
    .out_red    (blurred.red_out),
    .out_green  (blurred.green_out),
    .out_blue   (blurred.blue_out),
    .out_last   (blurred.row_last)
);

`default_nettype wire
